### hw/rtl/ens_pkg.sv
// shared types and constants for the edge non-maximum suppression block
`timescale 1ns / 1ps

package ens_pkg;

  // default sizes
  localparam int DefMaxWidth     = 1024;
  localparam int DefStrengthBits = 16;

  // fixed field widths
  localparam int ImgWidthW = 11;
  localparam int ThrW      = 16;
  localparam int CfgDataW  = 16;
  localparam int CfgIdxW   = 2;
  localparam int DirW      = 3;
  localparam int RowW      = 12;
  localparam int ColOutW   = 10;

  localparam logic [RowW-1:0] RowMax = RowW'(4095);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegImageWidth    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLowThreshold  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHighThreshold = 2'd2;

  // register reset values
  localparam logic [ImgWidthW-1:0] ImgWidthReset = ImgWidthW'(640);
  localparam logic [ThrW-1:0]      LowThrReset   = ThrW'(256);
  localparam logic [ThrW-1:0]      HighThrReset  = ThrW'(1024);

  // direction axes, low two bits of the direction code
  localparam logic [1:0] DirHoriz = 2'd0;
  localparam logic [1:0] DirDiag  = 2'd1;
  localparam logic [1:0] DirVert  = 2'd2;
  localparam logic [1:0] DirAnti  = 2'd3;

  // output queue
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  typedef enum logic [1:0] {
    ClsNone   = 2'd0,
    ClsWeak   = 2'd1,
    ClsStrong = 2'd2
  } edge_class_e;

  typedef struct packed {
    logic [ImgWidthW-1:0] img_width;
    logic [ThrW-1:0]      low_thr;
    logic [ThrW-1:0]      high_thr;
  } cfg_t;

  // raster position of the centre pixel and whether it is emitted
  typedef struct packed {
    logic               emit;
    logic [RowW-1:0]    row;
    logic [ColOutW-1:0] col;
  } pos_t;

  typedef struct packed {
    edge_class_e        cls;
    logic [RowW-1:0]    row;
    logic [ColOutW-1:0] col;
  } res_t;

endpackage

### hw/rtl/ens_front.sv
// raster position tracking, line store addressing and emission decision
`timescale 1ns / 1ps

module ens_front #(
  parameter int MAX_WIDTH = ens_pkg::DefMaxWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              acc_i,
  input  logic                              frame_start_i,
  input  logic [ens_pkg::ImgWidthW-1:0]     img_width_i,
  output logic [$clog2(MAX_WIDTH)-1:0]      addr_o,
  output ens_pkg::pos_t                     pos_o
);
  import ens_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int MW    = $clog2(MAX_WIDTH + 1);
  localparam int EW    = (ImgWidthW > MW) ? ImgWidthW : MW;
  localparam int ColXW = (CW > ColOutW) ? CW : ColOutW;

  logic [CW-1:0]   col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [CW-1:0]   col;
  logic [RowW-1:0] row;
  logic [EW-1:0]   width, col_x;
  logic [ColXW-1:0] col_out;
  logic            wrap;

  // clamp the programmed width to the supported range
  always_comb begin
    width = EW'(img_width_i);
    if (width < EW'(3)) width = EW'(3);
    if (width > EW'(MAX_WIDTH)) width = EW'(MAX_WIDTH);
  end

  assign col   = frame_start_i ? '0 : col_q;
  assign row   = frame_start_i ? '0 : row_q;
  assign col_x = EW'(col);
  assign wrap  = (col_x + EW'(1)) >= width;

  assign col_out = ColXW'(col) - ColXW'(1);

  assign addr_o     = col;
  assign pos_o.emit = (row >= RowW'(2)) && (col_x >= EW'(2)) && (col_x <= width - EW'(1));
  assign pos_o.row  = row - RowW'(1);
  assign pos_o.col  = col_out[ColOutW-1:0];

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc_i) begin
      if (wrap) begin
        col_d = '0;
        row_d = (row == RowMax) ? row : row + RowW'(1);
      end else begin
        col_d = col + CW'(1);
        row_d = row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### hw/rtl/ens_window.sv
// line stores, 3x3 strength window and double-threshold classification
`timescale 1ns / 1ps

module ens_window #(
  parameter int MAX_WIDTH     = ens_pkg::DefMaxWidth,
  parameter int STRENGTH_BITS = ens_pkg::DefStrengthBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr_i,
  input  logic [STRENGTH_BITS-1:0]      strength_i,
  input  logic [ens_pkg::DirW-1:0]      dir_i,
  input  ens_pkg::pos_t                 pos_i,
  input  logic [ens_pkg::ThrW-1:0]      low_thr_i,
  input  logic [ens_pkg::ThrW-1:0]      high_thr_i,
  output logic                          pending_o,
  output logic                          res_valid_o,
  output ens_pkg::res_t                 res_o
);
  import ens_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int SB   = STRENGTH_BITS;
  localparam int CmpW = (SB > ThrW) ? SB : ThrW;

  logic [SB-1:0]   line_a_mem [MAX_WIDTH];
  logic [SB-1:0]   line_b_mem [MAX_WIDTH];
  logic [DirW-1:0] dir_mem    [MAX_WIDTH];

  // stage one: item whose line store reads are in flight
  logic            v1_q;
  logic [CW-1:0]   addr1_q;
  logic [SB-1:0]   s1_q;
  pos_t            pos1_q;
  logic [SB-1:0]   rda_q, rdb_q;
  logic [DirW-1:0] rdd_q;
  logic            fwd_q;
  logic [SB-1:0]   fwd_data_q;

  logic [SB-1:0]   win_q [6];
  logic [DirW-1:0] cdir_q;

  logic [SB-1:0]   top, mid, n1, n2;
  logic [CmpW-1:0] cen_x, n1_x, n2_x;
  edge_class_e     cls;

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rda_q        <= line_a_mem[addr_i];
      rdb_q        <= line_b_mem[addr_i];
      rdd_q        <= dir_mem[addr_i];
      line_a_mem[addr_i] <= strength_i;
      dir_mem[addr_i]    <= dir_i;
      // row-two store written this edge at the same column: pass it along
      fwd_q        <= v1_q && (addr1_q == addr_i);
      fwd_data_q   <= rda_q;
      addr1_q      <= addr_i;
      s1_q         <= strength_i;
      pos1_q       <= pos_i;
    end
    if (v1_q) begin
      line_b_mem[addr1_q] <= rda_q;
    end
  end

  assign mid = rda_q;
  assign top = fwd_q ? fwd_data_q : rdb_q;

  // neighbours across the centre's direction
  always_comb begin
    case (cdir_q[1:0])
      DirHoriz: begin
        n1 = win_q[1];
        n2 = mid;
      end
      DirDiag: begin
        n1 = win_q[0];
        n2 = s1_q;
      end
      DirVert: begin
        n1 = win_q[3];
        n2 = win_q[5];
      end
      default: begin
        n1 = top;
        n2 = win_q[2];
      end
    endcase
  end

  assign cen_x = CmpW'(win_q[4]);
  assign n1_x  = CmpW'(n1);
  assign n2_x  = CmpW'(n2);

  always_comb begin
    cls = ClsNone;
    if (cen_x >= CmpW'(low_thr_i) && cen_x > n1_x && cen_x > n2_x) begin
      cls = (cen_x >= CmpW'(high_thr_i)) ? ClsStrong : ClsWeak;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      cdir_q <= '0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      v1_q <= acc_i;
      if (v1_q) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= s1_q;
        cdir_q   <= rdd_q;
      end
    end
  end

  assign pending_o   = v1_q & pos1_q.emit;
  assign res_valid_o = v1_q & pos1_q.emit;
  assign res_o.cls   = cls;
  assign res_o.row   = pos1_q.row;
  assign res_o.col   = pos1_q.col;

endmodule

### hw/rtl/ens_outq.sv
// result queue in front of the output channel
`timescale 1ns / 1ps

module ens_outq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  ens_pkg::res_t              push_data_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output ens_pkg::res_t              head_o,
  output logic [ens_pkg::QCntW-1:0]  count_o
);
  import ens_pkg::*;

  res_t             entry_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;
  logic             pop;

  assign pop = pop_i & (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) count_d = count_q + QCntW'(1);
    else if (!push_i && pop) count_d = count_q - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      count_q <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = entry_mem[rd_ptr_q];
  assign count_o = count_q;

endmodule

### hw/rtl/edge_nonmax_suppress_3x3.sv
// Streaming 3x3 non-maximum suppression with double threshold over a raster image.
// Input channel: one pixel per item (strength, direction, frame_start) in raster
// order; frame_start marks row 0, column 0 of a new image. Output channel: one
// item per interior pixel (class, row, column); border pixels give no item.
// The result for a centre pixel comes with the input item one row and one column
// past it and passes the window stage register and the result queue on its way to
// the output. Throughput is one item per cycle while in_stall_o is low: the line
// stores have one write and one read port each and the window takes one column per
// cycle. A four-entry result queue decouples the output; in_stall_o rises when
// queued plus in-flight results would fill it, so a stalled receiver stops the input
// after at most four results. Configuration (image width, low and high thresholds)
// is written through the plain write port; the user must write it only while the
// block is idle, which the block does not enforce. Reset clears the raster position,
// window and queue and loads the register defaults; the line stores keep their
// contents and need no clearing pass, and the block accepts items right after reset.
`timescale 1ns / 1ps

module edge_nonmax_suppress_3x3 #(
  parameter int MAX_WIDTH     = ens_pkg::DefMaxWidth,
  parameter int STRENGTH_BITS = ens_pkg::DefStrengthBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ens_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ens_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [STRENGTH_BITS-1:0]      pixel_strength_i,
  input  logic [ens_pkg::DirW-1:0]      pixel_direction_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    edge_class_o,
  output logic [ens_pkg::RowW-1:0]      out_row_o,
  output logic [ens_pkg::ColOutW-1:0]   out_col_o
);
  import ens_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  cfg_t             cfg_q;
  logic             acc;
  logic [CW-1:0]    addr;
  pos_t             pos;
  logic             pending;
  logic             res_valid;
  res_t             res, head;
  logic [QCntW-1:0] q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.img_width <= ImgWidthReset;
      cfg_q.low_thr   <= LowThrReset;
      cfg_q.high_thr  <= HighThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegImageWidth:    cfg_q.img_width <= cfg_data_i[ImgWidthW-1:0];
        RegLowThreshold:  cfg_q.low_thr   <= cfg_data_i[ThrW-1:0];
        RegHighThreshold: cfg_q.high_thr  <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // room for every result already queued or still in the window stage
  assign in_stall_o = (q_count + QCntW'(pending)) >= QCntW'(QDepth);
  assign acc        = in_valid_i & ~in_stall_o;

  ens_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .frame_start_i (frame_start_i),
    .img_width_i   (cfg_q.img_width),
    .addr_o        (addr),
    .pos_o         (pos)
  );

  ens_window #(
    .MAX_WIDTH     (MAX_WIDTH),
    .STRENGTH_BITS (STRENGTH_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .addr_i      (addr),
    .strength_i  (pixel_strength_i),
    .dir_i       (pixel_direction_i),
    .pos_i       (pos),
    .low_thr_i   (cfg_q.low_thr),
    .high_thr_i  (cfg_q.high_thr),
    .pending_o   (pending),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ens_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (~out_stall_i),
    .valid_o     (out_valid_o),
    .head_o      (head),
    .count_o     (q_count)
  );

  assign edge_class_o = head.cls;
  assign out_row_o    = head.row;
  assign out_col_o    = head.col;

endmodule

### test/tb_edge_nonmax_suppress_3x3.sv
// testbench for the 3x3 edge non-maximum suppression block with double threshold
`timescale 1ns / 1ps

module tb_edge_nonmax_suppress_3x3;
  import ens_pkg::*;

  localparam int MaxW = DefMaxWidth;
  localparam int StrMax = 65535;
  localparam int RowSat = 4095;
  // index past the register list, writes to it must be ignored
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic [15:0]  strength;
    logic [2:0]   dir;
    logic         frame_start;
    logic         typed;
    edge_class_e  cls;
  } dir_pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic pix_valid = 1'b0;
  logic [15:0] pix_strength = '0;
  logic [DirW-1:0] pix_dir = '0;
  logic pix_frame_start = 1'b0;
  logic out_stall = 1'b0;
  wire in_stall;
  wire out_valid;
  wire [1:0] edge_class;
  wire [RowW-1:0] out_row;
  wire [ColOutW-1:0] out_col;

  edge_nonmax_suppress_3x3 uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (pix_valid),
    .in_stall_o        (in_stall),
    .pixel_strength_i  (pix_strength),
    .pixel_direction_i (pix_dir),
    .frame_start_i     (pix_frame_start),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .edge_class_o      (edge_class),
    .out_row_o         (out_row),
    .out_col_o         (out_col)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: registers, raster position, line stores and window
  logic [ImgWidthW-1:0] cfg_width = ImgWidthReset;
  logic [ThrW-1:0] cfg_low = LowThrReset;
  logic [ThrW-1:0] cfg_high = HighThrReset;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic [15:0] strength_up1 [MaxW];
  logic [15:0] strength_up2 [MaxW];
  logic [DirW-1:0] dir_up1 [MaxW];
  logic [15:0] win [6] = '{default: '0};
  logic [DirW-1:0] centre_dir = '0;

  res_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_seen = 0;
  int unsigned weak_seen = 0;
  int unsigned strong_seen = 0;
  int unsigned highest_row = 0;
  int unsigned widest = 0;
  int unsigned setups = 0;
  int unsigned burst_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  // rows of a width-3 image; the class is typed in where it is obvious
  dir_pixel_t directed_pix [27] = '{
    '{16'd0,     3'd0, 1'b1, 1'b0, ClsNone},
    '{16'd0,     3'd6, 1'b0, 1'b0, ClsNone},
    '{16'd0,     3'd0, 1'b0, 1'b0, ClsNone},
    '{16'd0,     3'd7, 1'b0, 1'b0, ClsNone},
    '{16'd65535, 3'd0, 1'b0, 1'b0, ClsNone},
    '{16'd65534, 3'd0, 1'b0, 1'b0, ClsNone},
    '{16'd65535, 3'd0, 1'b0, 1'b0, ClsNone},
    '{16'd256,   3'd1, 1'b0, 1'b0, ClsNone},
    '{16'd0,     3'd0, 1'b0, 1'b1, ClsStrong},  // full scale beats horizontal pair
    '{16'd0,     3'd0, 1'b0, 1'b0, ClsNone},
    '{16'd1024,  3'd2, 1'b0, 1'b0, ClsNone},
    '{16'd255,   3'd0, 1'b0, 1'b1, ClsWeak},    // exactly at low threshold
    '{16'd0,     3'd0, 1'b0, 1'b0, ClsNone},
    '{16'd1023,  3'd3, 1'b0, 1'b0, ClsNone},
    '{16'd0,     3'd0, 1'b0, 1'b1, ClsStrong},  // exactly at high threshold
    '{16'd1023,  3'd0, 1'b0, 1'b0, ClsNone},
    '{16'd100,   3'd4, 1'b0, 1'b0, ClsNone},
    '{16'd0,     3'd0, 1'b0, 1'b1, ClsNone},    // tie with a neighbour
    '{16'd0,     3'd0, 1'b0, 1'b0, ClsNone},
    '{16'd200,   3'd6, 1'b0, 1'b0, ClsNone},
    '{16'd0,     3'd0, 1'b0, 1'b1, ClsNone},    // smaller than left neighbour
    '{16'd65535, 3'd0, 1'b0, 1'b0, ClsNone},
    '{16'd0,     3'd5, 1'b0, 1'b0, ClsNone},
    '{16'd65535, 3'd0, 1'b0, 1'b1, ClsNone},    // local max but below low
    '{16'd65535, 3'd7, 1'b0, 1'b0, ClsNone},
    '{16'd65535, 3'd7, 1'b0, 1'b0, ClsNone},
    '{16'd65535, 3'd4, 1'b0, 1'b0, ClsNone}
  };

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic classify_pixel(input logic [15:0] s, input logic [DirW-1:0] d,
                                input logic fs, output bit emits, output res_t res);
    int unsigned w;
    int unsigned c;
    logic [15:0] top, mid, ctr, n1, n2;
    w = cfg_width;
    if (w < 3) w = 3;
    if (w > MaxW) w = MaxW;
    if (w > widest) widest = w;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos % MaxW;
    top = strength_up2[c];
    mid = strength_up1[c];
    ctr = win[4];
    case (centre_dir[1:0])
      DirHoriz: begin
        n1 = win[1];
        n2 = mid;
      end
      DirDiag: begin
        n1 = win[0];
        n2 = s;
      end
      DirVert: begin
        n1 = win[3];
        n2 = win[5];
      end
      default: begin
        n1 = top;
        n2 = win[2];
      end
    endcase
    emits = (row_pos >= 2) && (col_pos >= 2) && (col_pos <= w - 1);
    res.cls = ClsNone;
    if (ctr >= cfg_low && ctr > n1 && ctr > n2)
      res.cls = (ctr >= cfg_high) ? ClsStrong : ClsWeak;
    res.row = RowW'(row_pos - 1);
    res.col = ColOutW'(col_pos - 1);
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = s;
    centre_dir = dir_up1[c];
    strength_up2[c] = mid;
    strength_up1[c] = s;
    dir_up1[c] = d;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos < RowSat) row_pos++;
    end else begin
      col_pos++;
    end
  endtask

  // offers one pixel, idling between bursts, and records what it should produce
  task automatic offer_pixel(input logic [15:0] s, input logic [DirW-1:0] d,
                             input logic fs, input bit typed, input edge_class_e typed_cls);
    int unsigned gap;
    bit emits;
    res_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pix_valid <= 1'b1;
    pix_strength <= s;
    pix_dir <= d;
    pix_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    burst_left--;
    pixels_sent++;
    classify_pixel(s, d, fs, emits, res);
    if (emits) begin
      if (typed) res.cls = typed_cls;
      pending_results.push_back(res);
    end
  endtask

  // stop offering and let every outstanding result come out
  task automatic drain();
    pix_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input int w, input int lo, input int hi);
    logic [CfgDataW-1:0] wdata;
    wdata = {5'($urandom_range(0, 31)), 11'(w)};
    cfg_we <= 1'b1;
    cfg_idx <= RegSpare;
    cfg_data <= 16'($urandom_range(0, StrMax));
    @(posedge clk);
    cfg_idx <= RegImageWidth;
    cfg_data <= wdata;
    @(posedge clk);
    cfg_width = wdata[ImgWidthW-1:0];
    cfg_idx <= RegLowThreshold;
    cfg_data <= 16'(lo);
    @(posedge clk);
    cfg_low = 16'(lo);
    cfg_idx <= RegHighThreshold;
    cfg_data <= 16'(hi);
    @(posedge clk);
    cfg_high = 16'(hi);
    cfg_we <= 1'b0;
    setups++;
  endtask

  // strengths cluster around the thresholds so maxima and ties are common
  function automatic logic [15:0] pick_strength();
    int v;
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, StrMax);
      1: v = int'(cfg_low) + int'($urandom_range(0, 8)) - 4;
      2: v = int'(cfg_high) + int'($urandom_range(0, 8)) - 4;
      3: v = $urandom_range(0, 7);
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > StrMax) v = StrMax;
    return 16'(v);
  endfunction

  task automatic run_phase(input int w, input int lo, input int hi, input int n,
                           input bit fresh, input bit noisy);
    logic fs;
    drain();
    program_regs(w, lo, hi);
    for (int i = 0; i < n; i++) begin
      fs = (i == 0 && fresh) || (noisy && $urandom_range(0, 299) == 0);
      offer_pixel(pick_strength(), DirW'($urandom_range(0, 7)), fs, 1'b0, ClsNone);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (edge_class == ClsWeak) weak_seen++;
      if (edge_class == ClsStrong) strong_seen++;
      if (out_row > highest_row) highest_row = out_row;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result class %0d row %0d col %0d",
                                  edge_class, out_row, out_col));
      end else begin
        want = pending_results.pop_front();
        if (edge_class !== want.cls || out_row !== want.row || out_col !== want.col)
          report_mismatch($sformatf(
            "got class %0d row %0d col %0d, expected class %0d row %0d col %0d",
            edge_class, out_row, out_col, want.cls, want.row, want.col));
      end
    end
  end

  // receiver stall pattern, with one long hold-off when asked
  initial begin
    int unsigned run;
    int unsigned mode;
    forever begin
      mode = $urandom_range(0, 3);
      run = $urandom_range(10, 120);
      repeat (run) begin
        @(posedge clk);
        if (hold_req && !hold_done) begin
          out_stall <= 1'b1;
          repeat (400) @(posedge clk);
          hold_done = 1'b1;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    int w, lo, hi;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    drain();
    program_regs(3, LowThrReset, HighThrReset);
    foreach (directed_pix[i])
      offer_pixel(directed_pix[i].strength, directed_pix[i].dir,
                  directed_pix[i].frame_start, directed_pix[i].typed, directed_pix[i].cls);
    // width below the minimum, thresholds at zero
    run_phase(0, 0, 0, 400, 1'b1, 1'b1);
    // thresholds at full scale, ends mid-row
    run_phase(20, StrMax, StrMax, 113, 1'b1, 1'b1);
    // width lowered past the current column, low above high
    run_phase(8, 5000, 100, 200, 1'b0, 1'b0);
    // width above the maximum, clamps to the widest image
    run_phase(2047, LowThrReset, HighThrReset, 3 * MaxW + 40, 1'b1, 1'b0);
    // narrow image long enough for the row count to saturate; the long
    // hold-off starts once the queue is empty, so pixels flow until in_stall holds them
    drain();
    hold_req = 1'b1;
    run_phase(1, 300, 2000, 3 * (RowSat + 5), 1'b1, 1'b0);
    repeat (8) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 200) : $urandom_range(3, 40);
      lo = $urandom_range(0, 3000);
      hi = $urandom_range(0, 6000);
      run_phase(w, lo, hi, 250, 1'b1, 1'b1);
    end
    drain();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never came", pending_results.size()));
    $display("covered %0d pixels over %0d register setups, %0d results (%0d weak, %0d strong)",
             pixels_sent, setups, results_seen, weak_seen, strong_seen);
    $display("image widths up to %0d, highest centre row %0d, %0d mismatches",
             widest, highest_row, mismatches);
    if (mismatches == 0) begin
      $display("tb_edge_nonmax_suppress_3x3: clean");
    end else begin
      $display("tb_edge_nonmax_suppress_3x3: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("tb_edge_nonmax_suppress_3x3: errors");
    $finish;
  end

endmodule

### files.f
hw/rtl/ens_pkg.sv
hw/rtl/ens_front.sv
hw/rtl/ens_window.sv
hw/rtl/ens_outq.sv
hw/rtl/edge_nonmax_suppress_3x3.sv
test/tb_edge_nonmax_suppress_3x3.sv
